// ----- design/preta_pkg.sv -----
package preta_pkg;

  localparam int unsigned ValW      = 32;
  localparam int unsigned EtaW      = 20;
  localparam int unsigned PctW      = 7;
  localparam int unsigned SecsW     = 19;
  localparam int unsigned DividendW = 64;
  localparam int unsigned DivisorW  = 42;
  localparam int unsigned StepCntW  = 5;
  localparam int unsigned CfgIdxW   = 2;

  localparam int unsigned InDataW   = 96;
  localparam int unsigned OutDataW  = 128;
  localparam int unsigned OutUserW  = 2;

  localparam logic [ValW-1:0] RangeHighRst = 32'd1000;
  localparam int unsigned     SettleMs     = 3000;
  localparam int unsigned     EtaCapSecs   = 99 * 3600;
  localparam int unsigned     MsPerSec     = 1000;
  localparam int unsigned     PctScale     = 100;

  // last step index of each division, two quotient bits per step
  localparam logic [StepCntW-1:0] PctLastStep  = 5'd19;
  localparam logic [StepCntW-1:0] EtaLastStep  = 5'd31;
  localparam logic [StepCntW-1:0] RateLastStep = 5'd20;
  localparam int unsigned PctShift  = DividendW - 2 * (19 + 1);
  localparam int unsigned RateShift = DividendW - 2 * (20 + 1);

  localparam logic [CfgIdxW-1:0] CfgRangeLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRangeHigh = 2'd1;

  localparam logic OpValue = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLAMP,
    S_TRACK,
    S_PCT,
    S_PCT_WAIT,
    S_ETA,
    S_ETA_WAIT,
    S_RATE,
    S_RATE_WAIT,
    S_OUT
  } state_e;

endpackage

// ----- design/preta_div.sv -----
module preta_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [preta_pkg::StepCntW-1:0]       last_i,
  input  logic [preta_pkg::DividendW-1:0]      dividend_i,
  input  logic [preta_pkg::DivisorW-1:0]       divisor_i,
  output logic                                 done_o,
  output logic [preta_pkg::DividendW-1:0]      quotient_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [preta_pkg::StepCntW-1:0]     cnt_q;
  logic [preta_pkg::DivisorW-1:0]     rem_q, rem_d;
  logic [preta_pkg::DivisorW-1:0]     dvs_q;
  logic [preta_pkg::DividendW-1:0]    quo_q, quo_d;

  // two restoring steps per cycle
  always_comb begin
    logic [preta_pkg::DivisorW:0] trial;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_d, quo_d[preta_pkg::DividendW-1]};
      quo_d = {quo_d[preta_pkg::DividendW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[preta_pkg::DivisorW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= last_i;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/progress_rate_eta_estimator.sv -----
// steps: accept, clamp; an empty range then goes straight to the result register, otherwise
// tracking, the percent division, the remaining-time and rate divisions when due, then output
// throughput: one word at a time, next word taken once the result is registered
// the three divisions share one divider at two quotient bits per cycle
// reset: range 0 to 1000, rate tracking cleared, both estimates unknown
module progress_rate_eta_estimator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // progress_value, byte_amount, time_ms
  input  logic [preta_pkg::InDataW-1:0]       s_axis_tdata_i,
  // opcode
  input  logic                                s_axis_tuser_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // percent, done_amount, total_amount, finished, remain_secs, rate_per_sec
  output logic [preta_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // label_shown, bytes_mode
  output logic [preta_pkg::OutUserW-1:0]      m_axis_tuser_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [preta_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [preta_pkg::ValW-1:0]          cfg_data_i
);

  preta_pkg::state_e state_q, state_d;

  logic [preta_pkg::ValW-1:0] range_low_q, range_low_d;
  logic [preta_pkg::ValW-1:0] range_high_q, range_high_d;
  logic [preta_pkg::ValW-1:0] last_value_q, last_value_d;
  logic                       started_q, started_d;
  logic [preta_pkg::ValW-1:0] start_time_q, start_time_d;
  logic [preta_pkg::ValW-1:0] base_done_q, base_done_d;
  logic [preta_pkg::ValW-1:0] base_sample_q, base_sample_d;
  logic [preta_pkg::EtaW-1:0] ssecs_q, ssecs_d;
  logic [preta_pkg::ValW-1:0] srate_q, srate_d;
  logic                       byte_mode_q, byte_mode_d;
  logic [preta_pkg::ValW-1:0] byte_total_q, byte_total_d;
  logic                       eta_go_q, eta_go_d;
  logic                       rate_go_q, rate_go_d;
  logic                       out_valid_q, out_valid_d;

  logic [preta_pkg::ValW-1:0]      now_q, now_d;
  logic [preta_pkg::ValW-1:0]      done_q, done_d;
  logic [preta_pkg::ValW-1:0]      total_q, total_d;
  logic [preta_pkg::ValW-1:0]      elapsed_q, elapsed_d;
  logic [preta_pkg::ValW-1:0]      remain_q, remain_d;
  logic [preta_pkg::ValW-1:0]      got_done_q, got_done_d;
  logic [preta_pkg::ValW-1:0]      got_sample_q, got_sample_d;
  logic [preta_pkg::DividendW-1:0] prod_q, prod_d;
  logic [preta_pkg::DivisorW-1:0]  eta_dvs_q, eta_dvs_d;
  logic [preta_pkg::PctW-1:0]      percent_q, percent_d;
  logic [preta_pkg::OutDataW-1:0]  out_data_q, out_data_d;
  logic [preta_pkg::OutUserW-1:0]  out_user_q, out_user_d;

  logic                             in_acc;
  logic                             cfg_wr;
  logic                             range_empty;
  logic                             out_load;
  logic [preta_pkg::ValW-1:0]       clamped;
  logic [preta_pkg::ValW-1:0]       sample;
  logic [preta_pkg::ValW-1:0]       elapsed_w;
  logic [preta_pkg::ValW-1:0]       in_value, in_bytes, in_time;
  logic [preta_pkg::SecsW-1:0]      secs;
  logic [preta_pkg::EtaW+1:0]       secs_acc;
  logic [preta_pkg::ValW+1:0]       rate_acc;

  logic                             div_start;
  logic [preta_pkg::StepCntW-1:0]   div_last;
  logic [preta_pkg::DividendW-1:0]  div_dividend;
  logic [preta_pkg::DivisorW-1:0]   div_divisor;
  logic                             div_done;
  logic [preta_pkg::DividendW-1:0]  div_quo;

  preta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .last_i     (div_last),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign s_axis_tready_o = (state_q == preta_pkg::S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_wr          = cfg_valid_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  assign in_value = s_axis_tdata_i[31:0];
  assign in_bytes = s_axis_tdata_i[63:32];
  assign in_time  = s_axis_tdata_i[95:64];

  assign range_empty = !(range_high_q > range_low_q);
  assign clamped     = (last_value_q < range_low_q)  ? range_low_q :
                       (last_value_q > range_high_q) ? range_high_q : last_value_q;
  assign sample      = byte_mode_q ? byte_total_q : done_q;
  assign elapsed_w   = now_q - start_time_q;
  assign out_load    = !out_valid_q || m_axis_tready_i;

  assign secs     = (div_quo > 64'(preta_pkg::EtaCapSecs)) ?
                    preta_pkg::SecsW'(preta_pkg::EtaCapSecs) : div_quo[preta_pkg::SecsW-1:0];
  assign secs_acc = {2'b00, ssecs_q} * 22'd3 + 22'(secs);
  assign rate_acc = {2'b00, srate_q} * 34'd3 + {2'b00, div_quo[preta_pkg::ValW-1:0]};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      preta_pkg::S_IDLE:      if (in_acc) state_d = preta_pkg::S_CLAMP;
      preta_pkg::S_CLAMP:     state_d = range_empty ? preta_pkg::S_OUT : preta_pkg::S_TRACK;
      preta_pkg::S_TRACK:     state_d = preta_pkg::S_PCT;
      preta_pkg::S_PCT:       state_d = preta_pkg::S_PCT_WAIT;
      preta_pkg::S_PCT_WAIT: begin
        if (div_done) begin
          state_d = eta_go_q  ? preta_pkg::S_ETA :
                    rate_go_q ? preta_pkg::S_RATE : preta_pkg::S_OUT;
        end
      end
      preta_pkg::S_ETA:       state_d = preta_pkg::S_ETA_WAIT;
      preta_pkg::S_ETA_WAIT: begin
        if (div_done) state_d = rate_go_q ? preta_pkg::S_RATE : preta_pkg::S_OUT;
      end
      preta_pkg::S_RATE:      state_d = preta_pkg::S_RATE_WAIT;
      preta_pkg::S_RATE_WAIT: if (div_done) state_d = preta_pkg::S_OUT;
      preta_pkg::S_OUT:       if (out_load) state_d = preta_pkg::S_IDLE;
      default:                state_d = preta_pkg::S_IDLE;
    endcase
  end

  // datapath and state updates
  always_comb begin
    range_low_d   = range_low_q;
    range_high_d  = range_high_q;
    last_value_d  = last_value_q;
    started_d     = started_q;
    start_time_d  = start_time_q;
    base_done_d   = base_done_q;
    base_sample_d = base_sample_q;
    ssecs_d       = ssecs_q;
    srate_d       = srate_q;
    byte_mode_d   = byte_mode_q;
    byte_total_d  = byte_total_q;
    eta_go_d      = eta_go_q;
    rate_go_d     = rate_go_q;
    now_d         = now_q;
    done_d        = done_q;
    total_d       = total_q;
    elapsed_d     = elapsed_q;
    remain_d      = remain_q;
    got_done_d    = got_done_q;
    got_sample_d  = got_sample_q;
    prod_d        = prod_q;
    eta_dvs_d     = eta_dvs_q;
    percent_d     = percent_q;
    out_data_d    = out_data_q;
    out_user_d    = out_user_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    div_start     = 1'b0;
    div_last      = '0;
    div_dividend  = '0;
    div_divisor   = '0;

    if (cfg_wr) begin
      case (cfg_index_i)
        preta_pkg::CfgRangeLow: begin
          range_low_d   = cfg_data_i;
          started_d     = 1'b0;
          start_time_d  = '0;
          base_done_d   = '0;
          base_sample_d = '0;
          ssecs_d       = '1;
          srate_d       = '1;
          byte_mode_d   = 1'b0;
          byte_total_d  = '0;
        end
        preta_pkg::CfgRangeHigh: range_high_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      preta_pkg::S_IDLE: begin
        if (in_acc) begin
          now_d = in_time;
          if (s_axis_tuser_i == preta_pkg::OpValue) begin
            last_value_d = in_value;
          end else begin
            if (!byte_mode_q || in_bytes < byte_total_q) begin
              base_sample_d = in_bytes;
              srate_d       = '1;
            end
            byte_mode_d  = 1'b1;
            byte_total_d = in_bytes;
          end
        end
      end
      preta_pkg::S_CLAMP: begin
        done_d  = clamped - range_low_q;
        total_d = range_high_q - range_low_q;
      end
      preta_pkg::S_TRACK: begin
        elapsed_d    = elapsed_w;
        remain_d     = total_q - done_q;
        got_done_d   = done_q - base_done_q;
        got_sample_d = sample - base_sample_q;
        eta_go_d     = 1'b0;
        rate_go_d    = 1'b0;
        if (done_q == '0 || done_q < base_done_q || sample < base_sample_q) begin
          started_d     = 1'b0;
          start_time_d  = '0;
          base_done_d   = '0;
          base_sample_d = '0;
          ssecs_d       = '1;
          srate_d       = '1;
        end else if (!started_q) begin
          started_d     = 1'b1;
          start_time_d  = now_q;
          base_done_d   = done_q;
          base_sample_d = sample;
        end else if (!(done_q <= base_done_q && sample <= base_sample_q) &&
                     elapsed_w >= preta_pkg::ValW'(preta_pkg::SettleMs)) begin
          eta_go_d  = done_q > base_done_q;
          rate_go_d = sample > base_sample_q;
        end
      end
      preta_pkg::S_PCT: begin
        div_start    = 1'b1;
        div_last     = preta_pkg::PctLastStep;
        div_dividend = ({32'd0, done_q} * 64'(preta_pkg::PctScale)) << preta_pkg::PctShift;
        div_divisor  = {10'd0, total_q};
        prod_d       = {32'd0, elapsed_q} * {32'd0, remain_q};
        eta_dvs_d    = {10'd0, got_done_q} * 42'(preta_pkg::MsPerSec);
      end
      preta_pkg::S_PCT_WAIT: begin
        if (div_done) percent_d = div_quo[preta_pkg::PctW-1:0];
      end
      preta_pkg::S_ETA: begin
        div_start    = 1'b1;
        div_last     = preta_pkg::EtaLastStep;
        div_dividend = prod_q;
        div_divisor  = eta_dvs_q;
      end
      preta_pkg::S_ETA_WAIT: begin
        if (div_done) begin
          ssecs_d = ssecs_q[preta_pkg::EtaW-1] ? preta_pkg::EtaW'(secs)
                                               : secs_acc[preta_pkg::EtaW+1:2];
        end
      end
      preta_pkg::S_RATE: begin
        div_start    = 1'b1;
        div_last     = preta_pkg::RateLastStep;
        div_dividend = ({32'd0, got_sample_q} * 64'(preta_pkg::MsPerSec))
                       << preta_pkg::RateShift;
        div_divisor  = {10'd0, elapsed_q};
      end
      preta_pkg::S_RATE_WAIT: begin
        if (div_done) begin
          srate_d = srate_q[preta_pkg::ValW-1] ? div_quo[preta_pkg::ValW-1:0]
                                               : rate_acc[preta_pkg::ValW+1:2];
        end
      end
      preta_pkg::S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (range_empty) begin
            out_data_d = '0;
            out_user_d = '0;
          end else begin
            out_data_d = {4'd0, srate_q, ssecs_q, (done_q >= total_q), total_q, done_q,
                          percent_q};
            out_user_d = {byte_mode_q, 1'b1};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= preta_pkg::S_IDLE;
      range_low_q   <= '0;
      range_high_q  <= preta_pkg::RangeHighRst;
      last_value_q  <= '0;
      started_q     <= 1'b0;
      start_time_q  <= '0;
      base_done_q   <= '0;
      base_sample_q <= '0;
      ssecs_q       <= '1;
      srate_q       <= '1;
      byte_mode_q   <= 1'b0;
      byte_total_q  <= '0;
      eta_go_q      <= 1'b0;
      rate_go_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      range_low_q   <= range_low_d;
      range_high_q  <= range_high_d;
      last_value_q  <= last_value_d;
      started_q     <= started_d;
      start_time_q  <= start_time_d;
      base_done_q   <= base_done_d;
      base_sample_q <= base_sample_d;
      ssecs_q       <= ssecs_d;
      srate_q       <= srate_d;
      byte_mode_q   <= byte_mode_d;
      byte_total_q  <= byte_total_d;
      eta_go_q      <= eta_go_d;
      rate_go_q     <= rate_go_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    done_q       <= done_d;
    total_q      <= total_d;
    elapsed_q    <= elapsed_d;
    remain_q     <= remain_d;
    got_done_q   <= got_done_d;
    got_sample_q <= got_sample_d;
    prod_q       <= prod_d;
    eta_dvs_q    <= eta_dvs_d;
    percent_q    <= percent_d;
    out_data_q   <= out_data_d;
    out_user_q   <= out_user_d;
  end

endmodule

// ----- bench/tb_progress_rate_eta_estimator.sv -----
module tb_progress_rate_eta_estimator;

  localparam logic                          OpBytes     = 1'b1;
  localparam logic [preta_pkg::CfgIdxW-1:0] CfgSpareA   = 2'd2;
  localparam logic [preta_pkg::CfgIdxW-1:0] CfgSpareB   = 2'd3;
  localparam int                            QuietLimit  = 2000;
  localparam int                            LongHold    = 300;
  localparam int                            DrainCycles = 100;

  typedef struct packed {
    logic                       op;
    logic [preta_pkg::ValW-1:0] val;
    logic [preta_pkg::ValW-1:0] amount;
    logic [preta_pkg::ValW-1:0] t;
  } report_in_t;

  typedef struct packed {
    logic                       shown;
    logic [preta_pkg::PctW-1:0] pct;
    logic [preta_pkg::ValW-1:0] done;
    logic [preta_pkg::ValW-1:0] total;
    logic                       fin;
    logic [preta_pkg::EtaW-1:0] eta;
    logic [preta_pkg::ValW-1:0] rate;
    logic                       bytes;
  } report_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic [preta_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [preta_pkg::OutDataW-1:0] m_axis_tdata;
  logic [preta_pkg::OutUserW-1:0] m_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [preta_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [preta_pkg::ValW-1:0]     cfg_data = '0;

  progress_rate_eta_estimator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // predictor copy of the configuration and tracking state
  logic [preta_pkg::ValW-1:0] lo_bound = '0;
  logic [preta_pkg::ValW-1:0] hi_bound = preta_pkg::RangeHighRst;
  logic [preta_pkg::ValW-1:0] prev_value = '0;
  logic                       rate_armed = 1'b0;
  logic [preta_pkg::ValW-1:0] t0_ms = '0;
  logic [preta_pkg::ValW-1:0] done_base = '0;
  logic [preta_pkg::ValW-1:0] sample_base = '0;
  int                         eta_avg = -1;
  int                         rate_avg = -1;
  logic                       counting_bytes = 1'b0;
  logic [preta_pkg::ValW-1:0] bytes_seen = '0;

  report_in_t pending_words[$];
  report_t    expected_reports[$];
  int         queued_total = 0;
  int         results_count = 0;
  int         cfg_writes = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;
  logic       idle_on = 1'b1;
  logic       word_taken = 1'b0;

  function automatic void clear_tracking();
    rate_armed  = 1'b0;
    t0_ms       = '0;
    done_base   = '0;
    sample_base = '0;
    eta_avg     = -1;
    rate_avg    = -1;
  endfunction

  // three quarters old estimate, one quarter new sample
  function automatic int blend(int prev, logic [preta_pkg::ValW-1:0] s);
    logic [63:0] acc;
    if (prev < 0) return $signed(s);
    acc = {32'd0, prev} * 64'd3 + {32'd0, s};
    return $signed(acc[33:2]);
  endfunction

  function automatic report_t predict_report(report_in_t w);
    report_t                    r;
    logic [preta_pkg::ValW-1:0] v, total, done, sample, elapsed;
    logic [63:0]                secs, per;
    r = '0;
    if (w.op == preta_pkg::OpValue) begin
      prev_value = w.val;
    end else begin
      if (!counting_bytes || w.amount < bytes_seen) begin
        sample_base = w.amount;
        rate_avg    = -1;
      end
      counting_bytes = 1'b1;
      bytes_seen     = w.amount;
    end
    if (hi_bound <= lo_bound) return r;
    v = prev_value;
    if (v < lo_bound) v = lo_bound;
    if (v > hi_bound) v = hi_bound;
    total   = hi_bound - lo_bound;
    done    = v - lo_bound;
    sample  = counting_bytes ? bytes_seen : done;
    elapsed = w.t - t0_ms;
    if (done == 0 || done < done_base || sample < sample_base) begin
      clear_tracking();
    end else if (!rate_armed) begin
      rate_armed  = 1'b1;
      t0_ms       = w.t;
      done_base   = done;
      sample_base = sample;
    end else if ((done > done_base || sample > sample_base) &&
                 elapsed >= preta_pkg::SettleMs) begin
      if (done > done_base) begin
        secs = 64'(elapsed) * 64'(total - done) / 64'(done - done_base)
               / 64'(preta_pkg::MsPerSec);
        if (secs > 64'(preta_pkg::EtaCapSecs)) secs = 64'(preta_pkg::EtaCapSecs);
        eta_avg = blend(eta_avg, secs[31:0]);
      end
      if (sample > sample_base) begin
        per = 64'(sample - sample_base) * 64'(preta_pkg::MsPerSec) / 64'(elapsed);
        rate_avg = blend(rate_avg, per[31:0]);
      end
    end
    r.shown = 1'b1;
    r.pct   = preta_pkg::PctW'(64'(done) * 64'(preta_pkg::PctScale) / 64'(total));
    r.done  = done;
    r.total = total;
    r.fin   = (done >= total);
    r.eta   = eta_avg[preta_pkg::EtaW-1:0];
    r.rate  = rate_avg;
    r.bytes = counting_bytes;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatches++;
    end
  endfunction

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    report_t exp, got;
    report_in_t w;
    if (rst_ni) begin
      word_taken <= s_axis_tvalid && s_axis_tready;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        results_count++;
        got.shown = m_axis_tuser[0];
        got.bytes = m_axis_tuser[1];
        got.pct   = m_axis_tdata[6:0];
        got.done  = m_axis_tdata[38:7];
        got.total = m_axis_tdata[70:39];
        got.fin   = m_axis_tdata[71];
        got.eta   = m_axis_tdata[91:72];
        got.rate  = m_axis_tdata[123:92];
        if (expected_reports.size() == 0) begin
          $error("unexpected result word: tdata %0h tuser %0h", m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          exp = expected_reports.pop_front();
          check_field("label_shown", 32'(exp.shown), 32'(got.shown));
          check_field("percent", 32'(exp.pct), 32'(got.pct));
          check_field("done_amount", exp.done, got.done);
          check_field("total_amount", exp.total, got.total);
          check_field("finished", 32'(exp.fin), 32'(got.fin));
          check_field("remain_secs", 32'(exp.eta), 32'(got.eta));
          check_field("rate_per_sec", exp.rate, got.rate);
          check_field("bytes_mode", 32'(exp.bytes), 32'(got.bytes));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        w.op     = s_axis_tuser;
        w.val    = s_axis_tdata[31:0];
        w.amount = s_axis_tdata[63:32];
        w.t      = s_axis_tdata[95:64];
        expected_reports.push_back(predict_report(w));
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        if (cfg_index == preta_pkg::CfgRangeLow) begin
          lo_bound = cfg_data;
          clear_tracking();
          counting_bytes = 1'b0;
          bytes_seen     = '0;
        end else if (cfg_index == preta_pkg::CfgRangeHigh) begin
          hi_bound = cfg_data;
        end
      end
    end
  end

  // sender
  int send_gap = 0;
  always @(negedge clk_i) begin
    report_in_t w;
    if (rst_ni && (!s_axis_tvalid || word_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        s_axis_tdata  <= {w.t, w.amount, w.val};
        s_axis_tuser  <= w.op;
        s_axis_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 7);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off while words are still queued
  int   hold_left = 0;
  logic long_hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && results_count > 150 && pending_words.size() > 10) begin
      long_hold_done = 1'b1;
      hold_left = LongHold - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog
  initial begin
    do @(negedge clk_i); while (quiet_cycles < QuietLimit);
    $display("tb_progress_rate_eta_estimator: errors");
    $finish;
  end

  task automatic queue_report(logic op, logic [preta_pkg::ValW-1:0] val,
                              logic [preta_pkg::ValW-1:0] amount,
                              logic [preta_pkg::ValW-1:0] t);
    report_in_t w;
    w.op     = op;
    w.val    = val;
    w.amount = amount;
    w.t      = t;
    pending_words.push_back(w);
    queued_total++;
  endtask

  task automatic write_reg(logic [preta_pkg::CfgIdxW-1:0] idx,
                           logic [preta_pkg::ValW-1:0] val);
    int seen;
    seen = cfg_writes;
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk_i); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (results_count != queued_total);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    logic [preta_pkg::ValW-1:0] lo, hi, span, stepmax, v, b, t;
    int                         count, sel;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset range: baseline, settle, estimates, clamp, backwards, byte reports
    queue_report(preta_pkg::OpValue, 32'd0, 32'd0, 32'd0);
    queue_report(preta_pkg::OpValue, 32'd100, 32'hFFFFFFFF, 32'd1000);
    queue_report(preta_pkg::OpValue, 32'd200, 32'd0, 32'd2000);
    queue_report(preta_pkg::OpValue, 32'd400, 32'd0, 32'd5000);
    queue_report(preta_pkg::OpValue, 32'd2000, 32'd0, 32'd9000);
    queue_report(preta_pkg::OpValue, 32'd50, 32'd0, 32'd10000);
    queue_report(OpBytes, 32'hFFFFFFFF, 32'd5000, 32'd11000);
    queue_report(OpBytes, 32'd0, 32'd9000, 32'd15000);
    queue_report(OpBytes, 32'd0, 32'd4000, 32'd16000);
    queue_report(OpBytes, 32'd0, 32'hFFFFFFFF, 32'd20000);
    queue_report(preta_pkg::OpValue, 32'hFFFFFFFF, 32'd0, 32'hFFFFF000);
    wait_drained();

    // range at the top of the value space, timestamp wrap, ignored indexes
    write_reg(preta_pkg::CfgRangeLow, 32'hFFFFFF00);
    write_reg(preta_pkg::CfgRangeHigh, 32'hFFFFFFFF);
    write_reg(CfgSpareA, $urandom);
    write_reg(CfgSpareB, $urandom);
    queue_report(preta_pkg::OpValue, 32'd0, 32'd0, 32'hFFFFF000);
    queue_report(preta_pkg::OpValue, 32'hFFFFFF10, 32'd0, 32'hFFFFF400);
    queue_report(preta_pkg::OpValue, 32'hFFFFFF80, 32'd0, 32'h00000800);
    queue_report(preta_pkg::OpValue, 32'hFFFFFFFF, 32'd0, 32'h00001000);
    wait_drained();

    // full range
    write_reg(preta_pkg::CfgRangeLow, 32'd0);
    queue_report(preta_pkg::OpValue, 32'd1, 32'd0, 32'd0);
    queue_report(preta_pkg::OpValue, 32'h80000000, 32'd0, 32'd4000);
    queue_report(OpBytes, 32'd0, 32'd0, 32'd5000);
    queue_report(OpBytes, 32'd0, 32'hFFFFFFFF, 32'd8000);
    wait_drained();

    // empty ranges
    write_reg(preta_pkg::CfgRangeLow, 32'd500);
    write_reg(preta_pkg::CfgRangeHigh, 32'd500);
    queue_report(preta_pkg::OpValue, 32'd700, 32'd0, 32'd100);
    queue_report(OpBytes, 32'd0, 32'd77, 32'd200);
    wait_drained();
    write_reg(preta_pkg::CfgRangeHigh, 32'd400);
    queue_report(preta_pkg::OpValue, 32'd450, 32'd0, 32'd300);
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      count = 60;
      case (ph)
        0, 6: begin
          lo = $urandom_range(0, 100);
          hi = lo + $urandom_range(1, 2000);
        end
        1: begin
          lo = $urandom;
          hi = $urandom;
          if (hi < lo) {lo, hi} = {hi, lo};
          if (hi == lo) hi = lo + 1;
        end
        2: begin
          lo = 32'd0;
          hi = 32'hFFFFFFFF;
        end
        3: begin
          lo = $urandom_range(10, 32'hFFFFFFFF);
          hi = lo - $urandom_range(0, 5);
          count = 15;
        end
        4: begin
          lo = 32'hFFFF0000 + $urandom_range(0, 32'h8000);
          hi = 32'hFFFFFFFF;
        end
        default: begin
          lo = $urandom_range(0, 1000000);
          hi = lo + $urandom_range(100, 1000000);
        end
      endcase
      idle_on = (ph != 6);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(preta_pkg::CfgRangeLow, lo);
        write_reg(preta_pkg::CfgRangeHigh, hi);
      end else begin
        write_reg(preta_pkg::CfgRangeHigh, hi);
        write_reg(preta_pkg::CfgRangeLow, lo);
      end
      span    = (hi > lo) ? hi - lo : 32'd0;
      stepmax = span / 8 + 1;
      v = lo;
      b = $urandom_range(0, 1000);
      t = $urandom;
      for (int n = 0; n < count; n++) begin
        t   = t + $urandom_range(100, 2500);
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          v = v + $urandom_range(0, stepmax);
          queue_report(preta_pkg::OpValue, v, $urandom, t);
        end else if (sel < 78) begin
          b = b + ($urandom & ((32'd1 << $urandom_range(1, 24)) - 1));
          queue_report(OpBytes, $urandom, b, t);
        end else if (sel < 85) begin
          v = v - $urandom_range(0, stepmax);
          queue_report(preta_pkg::OpValue, v, $urandom, t);
        end else if (sel < 90) begin
          b = b - $urandom_range(0, 5000);
          queue_report(OpBytes, $urandom, b, t);
        end else if (sel < 93) begin
          v = lo - $urandom_range(0, 10);
          queue_report(preta_pkg::OpValue, v, $urandom, t);
        end else begin
          queue_report(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        end
      end
      wait_drained();
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (expected_reports.size() != 0) begin
      $error("%0d expected results never arrived", expected_reports.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("tb_progress_rate_eta_estimator: clean");
    else
      $display("tb_progress_rate_eta_estimator: errors");
    $finish;
  end

endmodule
